>>> hw/rtl/lgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Normalized Legendre package
// Shared types, constants and helper functions for the value and slope unit.
// ----------------------------------------------------------------------------
package lgd_pkg;

	// Largest order and degree handled; the 6-bit fields never exceed it.
	localparam int unsigned MAX_ORDER = 63;

	// Argument limits in Q1.30.
	localparam logic signed [31:0] X_ONE = 32'sh4000_0000;

	// Saturation limits.
	localparam logic signed [63:0] Q40_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0]        VALUE_LIM = 64'h0000_0000_7FFF_FFFF;
	localparam logic [127:0]       SLOPE_LIM = 128'h7FFF_FFFF_FFFF;

	// Status codes.
	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_DEG  = 2'd1;
	localparam logic [1:0] STATUS_POLE = 2'd2;

	typedef struct packed {
		logic [5:0]         order_n;
		logic [5:0]         degree_m;
		logic signed [31:0] x_arg;
	} lgd_in_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [47:0] slope;
		logic [1:0]         status;
	} lgd_out_t;

	// Multiplier request and response.
	typedef struct packed {
		logic               go;
		logic               sh40;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} lgd_mul_req_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] prod;
	} lgd_mul_rsp_t;

	// Divider request and response.
	typedef struct packed {
		logic         go;
		logic [127:0] num;
		logic [63:0]  den;
	} lgd_div_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] quot;
	} lgd_div_rsp_t;

	// Square root request and response.
	typedef struct packed {
		logic         go;
		logic [127:0] rad;
	} lgd_sqrt_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] root;
	} lgd_sqrt_rsp_t;

	// Magnitude of a signed 64-bit value.
	function automatic logic [63:0] lgd_umag(input logic signed [63:0] a);
		return a[63] ? 64'(-a) : 64'(a);
	endfunction

	// Saturating subtraction, limited to plus or minus (2^63-1).
	function automatic logic signed [63:0] lgd_ssub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] d;
		logic signed [64:0] lim;
		lim = 65'(Q40_MAX);
		d = 65'(a) - 65'(b);
		if (d > lim)
			return Q40_MAX;
		else if (d < -lim)
			return -Q40_MAX;
		else
			return d[63:0];
	endfunction

endpackage

>>> hw/rtl/lgd_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative fixed-point multiplier
// Multiplies two signed 64-bit values with four 32x32 partial products, then
// rounds to nearest (ties away from zero), shifts by 40 or 30 and saturates.
// ----------------------------------------------------------------------------
module lgd_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lgd_pkg::lgd_mul_req_t req,
	output lgd_pkg::lgd_mul_rsp_t rsp
);
	import lgd_pkg::*;

	logic [63:0]  am_q, bm_q;
	logic         neg_q, sh40_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         busy_q, rnd_q, done_q;
	logic signed [63:0] prod_q;

	logic [31:0]  ah_w, bh_w;
	logic [63:0]  pp_w;
	logic [1:0]   pos_w;
	logic [127:0] ppx_w;
	logic [127:0] racc_w, shf_w;
	logic [62:0]  mag_w;

	// Select the partial product for this cycle and align it.
	always_comb begin
		ah_w  = cnt_q[1] ? am_q[63:32] : am_q[31:0];
		bh_w  = cnt_q[0] ? bm_q[63:32] : bm_q[31:0];
		pp_w  = ah_w * bh_w;
		pos_w = 2'(cnt_q[1]) + 2'(cnt_q[0]);
		ppx_w = {64'b0, pp_w} << {pos_w, 5'b0};
	end

	// Rounding, scaling and saturation of the finished product.
	always_comb begin
		racc_w = acc_q + (sh40_q ? (128'd1 << 39) : (128'd1 << 29));
		shf_w  = sh40_q ? (racc_w >> 40) : (racc_w >> 30);
		mag_w  = (shf_w[127:63] != '0) ? Q40_MAX[62:0] : shf_w[62:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				am_q   <= lgd_umag(req.a);
				bm_q   <= lgd_umag(req.b);
				neg_q  <= req.a[63] ^ req.b[63];
				sh40_q <= req.sh40;
				acc_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= acc_q + ppx_w;
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					rnd_q  <= 1'b1;
				end
			end else if (rnd_q) begin
				rnd_q  <= 1'b0;
				done_q <= 1'b1;
				prod_q <= neg_q ? -$signed({1'b0, mag_w}) : $signed({1'b0, mag_w});
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = prod_q;

endmodule

>>> hw/rtl/lgd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Divides a 128-bit numerator by a 64-bit divisor below 2^63, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module lgd_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lgd_pkg::lgd_div_req_t req,
	output lgd_pkg::lgd_div_rsp_t rsp
);
	import lgd_pkg::*;

	logic [127:0] num_q;
	logic [63:0]  den_q, rem_q;
	logic [6:0]   cnt_q;
	logic         busy_q, done_q;

	logic [64:0]  rsh_w, rnx_w;
	logic         ge_w;

	// One shift and trial subtraction.
	always_comb begin
		rsh_w = {rem_q, num_q[127]};
		ge_w  = rsh_w >= {1'b0, den_q};
		rnx_w = ge_w ? rsh_w - {1'b0, den_q} : rsh_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				num_q  <= req.num;
				den_q  <= req.den;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= rnx_w[63:0];
				num_q <= {num_q[126:0], ge_w};
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;

endmodule

>>> hw/rtl/lgd_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Digit-by-digit square root
// Floor square root of a 128-bit radicand, one root bit per cycle.
// ----------------------------------------------------------------------------
module lgd_sqrt (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lgd_pkg::lgd_sqrt_req_t req,
	output lgd_pkg::lgd_sqrt_rsp_t rsp
);
	import lgd_pkg::*;

	logic [127:0] rad_q;
	logic [65:0]  rem_q;
	logic [63:0]  root_q;
	logic [5:0]   cnt_q;
	logic         busy_q, done_q;

	logic [67:0]  rsh_w, trial_w, rnx_w;
	logic         ge_w;

	// Bring down two radicand bits and try the next root bit.
	always_comb begin
		rsh_w   = {rem_q, rad_q[127:126]};
		trial_w = {2'b0, root_q, 2'b01};
		ge_w    = rsh_w >= trial_w;
		rnx_w   = ge_w ? rsh_w - trial_w : rsh_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				rad_q  <= req.rad;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rad_q  <= {rad_q[125:0], 2'b00};
				rem_q  <= rnx_w[65:0];
				root_q <= {root_q[62:0], ge_w};
				cnt_q  <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

>>> hw/rtl/normalized_legendre_value_and_slope_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Normalized Legendre value and slope unit
// Sequencer around a shared multiplier, divider and square root unit.
// ----------------------------------------------------------------------------
// The unit takes one item at a time and is not ready while it works. Each
// ratio square root is a division followed by a root, and each product
// runs on the shared multiplier; an item whose degree exceeds the order
// goes straight to the output. The division and root units take most of
// the time of an item. A finished result sits in an output register, so the
// next transfer in is taken while it waits.
module normalized_legendre_value_and_slope_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lgd_pkg::lgd_in_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output lgd_pkg::lgd_out_t out_data
);
	import lgd_pkg::*;

	// Sequencer states.
	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_XSQ    = 5'd1;
	localparam logic [4:0] S_DEN    = 5'd2;
	localparam logic [4:0] S_P00    = 5'd3;
	localparam logic [4:0] S_P00D   = 5'd4;
	localparam logic [4:0] S_DIAG   = 5'd5;
	localparam logic [4:0] S_DG1    = 5'd6;
	localparam logic [4:0] S_DG2    = 5'd7;
	localparam logic [4:0] S_DG3    = 5'd8;
	localparam logic [4:0] S_REC    = 5'd9;
	localparam logic [4:0] S_RC1    = 5'd10;
	localparam logic [4:0] S_RC2    = 5'd11;
	localparam logic [4:0] S_RC3    = 5'd12;
	localparam logic [4:0] S_RC4    = 5'd13;
	localparam logic [4:0] S_RC5    = 5'd14;
	localparam logic [4:0] S_RC6    = 5'd15;
	localparam logic [4:0] S_FIN    = 5'd16;
	localparam logic [4:0] S_FN1    = 5'd17;
	localparam logic [4:0] S_FN2    = 5'd18;
	localparam logic [4:0] S_FN3    = 5'd19;
	localparam logic [4:0] S_FN4    = 5'd20;
	localparam logic [4:0] S_MUL_W  = 5'd21;
	localparam logic [4:0] S_DIV_W  = 5'd22;
	localparam logic [4:0] S_SQ_W   = 5'd23;
	localparam logic [4:0] S_DIVO_W = 5'd24;
	localparam logic [4:0] S_OUT    = 5'd25;

	logic [4:0]  st_q, ret_q;
	logic [5:0]  n_q, m_q;
	logic [6:0]  k_q;
	logic signed [31:0] x_q;
	logic [60:0] xx_q, den_q;
	logic signed [63:0] s_q, p1_q, p2_q, pn_q, tmp_q, res_q;
	logic signed [31:0] val_q;
	logic signed [47:0] slp_q;
	logic [1:0]  sts_q;
	logic        out_valid_q;
	lgd_out_t    out_data_q;

	lgd_mul_req_t  mul_req_q;
	lgd_mul_rsp_t  mul_rsp;
	lgd_div_req_t  div_req_q;
	lgd_div_rsp_t  div_rsp;
	lgd_sqrt_req_t sq_req_q;
	lgd_sqrt_rsp_t sq_rsp;

	logic signed [31:0] xin_w;
	logic [30:0] xm_w;
	logic [61:0] xx_w;
	logic [6:0]  j_w, np1_w;
	logic [13:0] kk_w, jj_w, mm_w, nn1_w;
	logic [19:0] rp_w, rq_w;
	logic [127:0] rnum_w, snum_w;
	logic signed [39:0] xn_w;
	logic [63:0] pnm_w, vr_w;
	logic [46:0] smg_w;

	// Shared arithmetic units.
	lgd_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req_q), .rsp(mul_rsp));
	lgd_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req_q), .rsp(div_rsp));
	lgd_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sq_req_q), .rsp(sq_rsp));

	// Argument clamped to [-1,1] and its square.
	always_comb begin
		if (in_data.x_arg > X_ONE)
			xin_w = X_ONE;
		else if (in_data.x_arg < -X_ONE)
			xin_w = -X_ONE;
		else
			xin_w = in_data.x_arg;
		xm_w = x_q[31] ? 31'(-x_q) : 31'(x_q);
		xx_w = xm_w * xm_w;
	end

	// Small integer terms of the recurrence coefficients.
	always_comb begin
		j_w   = k_q - 7'd1;
		np1_w = {1'b0, n_q} + 7'd1;
		kk_w  = k_q * k_q;
		jj_w  = j_w * j_w;
		mm_w  = m_q * m_q;
		nn1_w = np1_w * np1_w;
		xn_w  = x_q * $signed({1'b0, np1_w});
	end

	// Ratio p/q whose square root the current state asks for.
	always_comb begin
		case (st_q)
			S_P00: begin
				rp_w = 20'd1;
				rq_w = 20'd2;
			end
			S_DG1: begin
				rp_w = {12'b0, k_q, 1'b1};
				rq_w = {12'b0, k_q, 1'b0};
			end
			S_RC1: begin
				rp_w = 20'(jj_w - mm_w);
				rq_w = {4'b0, jj_w, 2'b0} - 20'd1;
			end
			S_RC4: begin
				rp_w = {4'b0, kk_w, 2'b0} - 20'd1;
				rq_w = 20'(kk_w - mm_w);
			end
			S_FIN: begin
				rp_w = 20'({n_q, 1'b1}) * 20'(nn1_w - mm_w);
				rq_w = 20'({n_q, 1'b1}) + 20'd2;
			end
			default: begin
				rp_w = '0;
				rq_w = '0;
			end
		endcase
		rnum_w = {28'b0, rp_w, 80'b0};
	end

	// Final value rounding and the slope dividend.
	always_comb begin
		pnm_w  = lgd_umag(pn_q);
		vr_w   = (pnm_w >> 15) + 64'(pnm_w[14]);
		snum_w = {19'b0, lgd_umag(tmp_q), 45'b0} + 128'(den_q >> 1);
		smg_w  = (div_rsp.quot > SLOPE_LIM) ? SLOPE_LIM[46:0] : div_rsp.quot[46:0];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			ret_q       <= S_IDLE;
			out_valid_q <= 1'b0;
			mul_req_q   <= '0;
			div_req_q   <= '0;
			sq_req_q    <= '0;
		end else begin
			mul_req_q.go <= 1'b0;
			div_req_q.go <= 1'b0;
			sq_req_q.go  <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						n_q <= in_data.order_n;
						m_q <= in_data.degree_m;
						x_q <= xin_w;
						if (in_data.degree_m > in_data.order_n) begin
							val_q <= '0;
							slp_q <= '0;
							sts_q <= STATUS_DEG;
							st_q  <= S_OUT;
						end else begin
							st_q <= S_XSQ;
						end
					end
				end
				S_XSQ: begin
					xx_q <= xx_w[60:0];
					st_q <= S_DEN;
				end
				S_DEN: begin
					den_q    <= {1'b1, 60'b0} - xx_q;
					sq_req_q <= '{go: 1'b1, rad: {47'b0, {1'b1, 60'b0} - xx_q, 20'b0}};
					ret_q    <= S_P00;
					st_q     <= S_SQ_W;
				end
				S_P00: begin
					s_q       <= res_q;
					div_req_q <= '{go: 1'b1, num: rnum_w, den: 64'(rq_w)};
					ret_q     <= S_P00D;
					st_q      <= S_DIV_W;
				end
				S_P00D: begin
					p1_q <= res_q;
					k_q  <= 7'd1;
					st_q <= S_DIAG;
				end
				// Diagonal product up to degree m.
				S_DIAG: begin
					if (k_q > {1'b0, m_q}) begin
						if (m_q[0]) begin
							p1_q <= -p1_q;
							pn_q <= -p1_q;
						end else begin
							pn_q <= p1_q;
						end
						p2_q <= '0;
						k_q  <= {1'b0, m_q} + 7'd1;
						st_q <= S_REC;
					end else begin
						mul_req_q <= '{go: 1'b1, sh40: 1'b1, a: p1_q, b: s_q};
						ret_q     <= S_DG1;
						st_q      <= S_MUL_W;
					end
				end
				S_DG1: begin
					tmp_q     <= res_q;
					div_req_q <= '{go: 1'b1, num: rnum_w, den: 64'(rq_w)};
					ret_q     <= S_DG2;
					st_q      <= S_DIV_W;
				end
				S_DG2: begin
					mul_req_q <= '{go: 1'b1, sh40: 1'b1, a: tmp_q, b: res_q};
					ret_q     <= S_DG3;
					st_q      <= S_MUL_W;
				end
				S_DG3: begin
					p1_q <= res_q;
					k_q  <= k_q + 7'd1;
					st_q <= S_DIAG;
				end
				// Three-term upward recurrence up to order n+1.
				S_REC: begin
					if (k_q > np1_w) begin
						st_q <= S_FIN;
					end else begin
						mul_req_q <= '{go: 1'b1, sh40: 1'b0, a: p1_q, b: 64'(x_q)};
						ret_q     <= S_RC1;
						st_q      <= S_MUL_W;
					end
				end
				S_RC1: begin
					tmp_q <= res_q;
					if (k_q >= {1'b0, m_q} + 7'd2) begin
						div_req_q <= '{go: 1'b1, num: rnum_w, den: 64'(rq_w)};
						ret_q     <= S_RC2;
						st_q      <= S_DIV_W;
					end else begin
						st_q <= S_RC4;
					end
				end
				S_RC2: begin
					mul_req_q <= '{go: 1'b1, sh40: 1'b1, a: p2_q, b: res_q};
					ret_q     <= S_RC3;
					st_q      <= S_MUL_W;
				end
				S_RC3: begin
					tmp_q <= lgd_ssub(tmp_q, res_q);
					st_q  <= S_RC4;
				end
				S_RC4: begin
					div_req_q <= '{go: 1'b1, num: rnum_w, den: 64'(rq_w)};
					ret_q     <= S_RC5;
					st_q      <= S_DIV_W;
				end
				S_RC5: begin
					mul_req_q <= '{go: 1'b1, sh40: 1'b1, a: tmp_q, b: res_q};
					ret_q     <= S_RC6;
					st_q      <= S_MUL_W;
				end
				S_RC6: begin
					p2_q <= p1_q;
					p1_q <= res_q;
					if (k_q == {1'b0, n_q})
						pn_q <= res_q;
					k_q  <= k_q + 7'd1;
					st_q <= S_REC;
				end
				// Value rounding, then the slope unless x sits at a pole.
				S_FIN: begin
					if (vr_w > VALUE_LIM)
						val_q <= pn_q[63] ? -$signed(VALUE_LIM[31:0]) : $signed(VALUE_LIM[31:0]);
					else
						val_q <= pn_q[63] ? -$signed(vr_w[31:0]) : $signed(vr_w[31:0]);
					if (den_q == '0) begin
						slp_q <= $signed(SLOPE_LIM[47:0]);
						sts_q <= STATUS_POLE;
						st_q  <= S_OUT;
					end else begin
						sts_q     <= STATUS_OK;
						div_req_q <= '{go: 1'b1, num: rnum_w, den: 64'(rq_w)};
						ret_q     <= S_FN1;
						st_q      <= S_DIV_W;
					end
				end
				S_FN1: begin
					tmp_q     <= res_q;
					mul_req_q <= '{go: 1'b1, sh40: 1'b0, a: pn_q, b: 64'(xn_w)};
					ret_q     <= S_FN2;
					st_q      <= S_MUL_W;
				end
				S_FN2: begin
					p2_q      <= res_q;
					mul_req_q <= '{go: 1'b1, sh40: 1'b1, a: p1_q, b: tmp_q};
					ret_q     <= S_FN3;
					st_q      <= S_MUL_W;
				end
				S_FN3: begin
					tmp_q <= lgd_ssub(p2_q, res_q);
					st_q  <= S_FN4;
				end
				S_FN4: begin
					div_req_q <= '{go: 1'b1, num: snum_w, den: 64'(den_q)};
					st_q      <= S_DIVO_W;
				end
				// Shared waits: product, ratio root, plain root, slope quotient.
				S_MUL_W: begin
					if (mul_rsp.done) begin
						res_q <= mul_rsp.prod;
						st_q  <= ret_q;
					end
				end
				S_DIV_W: begin
					if (div_rsp.done) begin
						sq_req_q <= '{go: 1'b1, rad: div_rsp.quot};
						st_q     <= S_SQ_W;
					end
				end
				S_SQ_W: begin
					if (sq_rsp.done) begin
						res_q <= $signed(sq_rsp.root);
						st_q  <= ret_q;
					end
				end
				S_DIVO_W: begin
					if (div_rsp.done) begin
						slp_q <= tmp_q[63] ? -$signed({1'b0, smg_w}) : $signed({1'b0, smg_w});
						st_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_data_q  <= '{value: val_q, slope: slp_q, status: sts_q};
						out_valid_q <= 1'b1;
						st_q        <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (st_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A unit only finishes while the sequencer waits for it.
	a_mul_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> st_q == S_MUL_W)
		else $error("multiplier finished outside its wait state");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (st_q == S_DIV_W || st_q == S_DIVO_W))
		else $error("divider finished outside its wait state");

	a_sqrt_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sq_rsp.done |-> st_q == S_SQ_W)
		else $error("square root finished outside its wait state");

	// The recurrence never runs past order n+1.
	a_rec_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_REC |-> k_q <= np1_w + 7'd1)
		else $error("recurrence index overran the order");

	// A degree above the order gives a zero result.
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == STATUS_DEG) |->
		(out_data.value == '0 && out_data.slope == '0))
		else $error("degree error with non-zero result");

endmodule
